### src/eod_pkg.sv
package eod_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int COEF_W   = 17;
	localparam int WIN_W    = 17;
	localparam int THR_W    = 16;
	localparam int ENV_W    = 24;
	localparam int MAG_W    = 16;

	// Shared multiplier: 24-bit by 17-bit unsigned
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [ENV_W-1:0]  ENV_MAX  = {ENV_W{1'b1}};
	localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEF      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_WINDOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_SAMPLES = 3'd6;

	localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd4096;
	localparam logic [COEF_W-1:0] ATTACK_RESET = 17'd45426;

	typedef struct packed {
		logic [GAIN_W-1:0] level_gain;
		logic [COEF_W-1:0] attack_coef;
		logic [COEF_W-1:0] decay_coef;
		logic [THR_W-1:0]  ratio_threshold;
		logic [ENV_W-1:0]  diff_threshold;
		logic [ENV_W-1:0]  holdoff_samples;
	} eod_cfg_t;

	// One strobe per datapath step
	typedef struct packed {
		logic accept;
		logic mul_gain;
		logic sub;
		logic mul_coef;
		logic update;
		logic read;
		logic mul_thr;
		logic finish;
	} eod_cmd_t;

endpackage

### src/eod_ram.sv
module eod_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/eod_winmod.sv
module eod_winmod #(
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [eod_pkg::WIN_W-1:0] window,
	output logic                     busy,
	output logic [$clog2(DEPTH)-1:0] win_mod
);
	import eod_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int RW = AW + WIN_W + 1;
	// Depth reciprocal scaled by 2^WIN_W; zero once the depth exceeds 2^WIN_W
	localparam logic [WIN_W-1:0] RECIP   = WIN_W'((1 << WIN_W) / DEPTH);
	localparam logic [RW-1:0]    DEPTH_R = RW'(DEPTH);

	logic [WIN_W-1:0]   w_q;
	logic [WIN_W-1:0]   quot_q;
	logic [RW-1:0]      r_q;
	logic [1:0]         cnt_q;
	logic               busy_q;
	logic [2*WIN_W-1:0] recip_prod;
	logic [RW-1:0]      back_prod;

	// Quotient estimate is low by at most one, so one compare and subtract finishes
	assign recip_prod = (2*WIN_W)'(w_q) * (2*WIN_W)'(RECIP);
	assign back_prod  = RW'(quot_q) * DEPTH_R;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= '0;
			quot_q <= '0;
			r_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			w_q    <= window;
			cnt_q  <= 2'd2;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			unique case (cnt_q)
				2'd2: quot_q <= recip_prod[2*WIN_W-1:WIN_W];
				2'd1: r_q    <= RW'(w_q) - back_prod;
				default: begin
					if (r_q >= DEPTH_R) begin
						r_q <= r_q - DEPTH_R;
					end
				end
			endcase
			if (cnt_q == 2'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign busy    = busy_q;
	assign win_mod = AW'(r_q);

endmodule

### src/eod_ctrl.sv
module eod_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              win_busy,
	output eod_pkg::eod_cmd_t cmd
);
	import eod_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MULG = 3'd1;
	localparam logic [2:0] ST_SUB  = 3'd2;
	localparam logic [2:0] ST_MULC = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_RD   = 3'd5;
	localparam logic [2:0] ST_MULT = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       fin_go;

	assign in_ready = (state_q == ST_IDLE) && !win_busy;
	assign accept   = in_valid && in_ready;
	// Hold in the last step while the previous beat still waits
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_MULG;
			ST_MULG: state_d = ST_SUB;
			ST_SUB:  state_d = ST_MULC;
			ST_MULC: state_d = ST_UPD;
			ST_UPD:  state_d = ST_RD;
			ST_RD:   state_d = ST_MULT;
			ST_MULT: state_d = ST_FIN;
			ST_FIN:  if (fin_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign cmd.accept   = accept;
	assign cmd.mul_gain = (state_q == ST_MULG);
	assign cmd.sub      = (state_q == ST_SUB);
	assign cmd.mul_coef = (state_q == ST_MULC);
	assign cmd.update   = (state_q == ST_UPD);
	assign cmd.read     = (state_q == ST_RD);
	assign cmd.mul_thr  = (state_q == ST_MULT);
	assign cmd.finish   = fin_go;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result beat raised outside the final step");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out_ready) |=>
		(state_q == ST_FIN && out_valid_q))
		else $error("final step left while the output register was full");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_MULG)
		else $error("accepted beat did not start the sequence");

endmodule

### src/eod_dp.sv
module eod_dp #(
	parameter int DEPTH = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  eod_pkg::eod_cmd_t           cmd,
	input  eod_pkg::eod_cfg_t           cfg,
	input  logic [$clog2(DEPTH)-1:0]    win_mod,
	input  logic signed [eod_pkg::SAMPLE_W-1:0] sample,
	input  logic                        first,
	output logic                        onset,
	output logic [eod_pkg::ENV_W-1:0]   envelope
);
	import eod_pkg::*;

	localparam int               AW       = $clog2(DEPTH);
	localparam logic [AW-1:0]    LAST_POS = AW'(DEPTH - 1);
	localparam logic [AW:0]      DEPTH_X  = (AW + 1)'(DEPTH);

	// Payload registers
	logic [MAG_W-1:0]  mag_q;
	logic [PROD_W-1:0] p_q;
	logic [ENV_W-1:0]  diff_q;
	logic [COEF_W-1:0] coef_q;
	logic              rising_q;
	logic              e_valid_q;
	logic              diff_ok_q;
	logic              onset_q;
	logic [ENV_W-1:0]  envelope_q;

	// Run state
	logic [ENV_W-1:0]  env_q;
	logic [AW-1:0]     wp_q;
	logic              wrapped_q;
	logic              prev_q;
	logic [ENV_W-1:0]  hc_q;
	logic              fire_ready_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod_c;
	logic [MAG_W-1:0]   mag_c;
	logic [ENV_W-1:0]   rect_c;
	logic               rising_c;
	logic [COEF_W-1:0]  coef_sel;
	logic [COEF_W-1:0]  coef_sat;
	logic [ENV_W:0]     step_c;
	logic [ENV_W+1:0]   rise_sum;
	logic [ENV_W-1:0]   env_up;
	logic [ENV_W-1:0]   env_dn;
	logic [ENV_W-1:0]   env_new;
	logic [AW-1:0]      wp_next;
	logic [AW:0]        rd_sum;
	logic [AW:0]        rd_wrap;
	logic [AW-1:0]      rd_addr;
	logic               rd_valid_c;
	logic [ENV_W-1:0]   ram_rdata;
	logic [ENV_W-1:0]   e_c;
	logic [ENV_W-1:0]   abs_c;
	logic               ratio_ok;
	logic               cond_c;
	logic               onset_c;
	logic [ENV_W-1:0]   hc_base;
	logic [ENV_W-1:0]   hc_inc;

	assign mag_c = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);

	// One multiplier, three uses
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul_gain) begin
			mul_a = MUL_A_W'(mag_q);
			mul_b = MUL_B_W'(cfg.level_gain);
		end else if (cmd.mul_coef) begin
			mul_a = diff_q;
			mul_b = coef_q;
		end else if (cmd.mul_thr) begin
			mul_a = e_c;
			mul_b = MUL_B_W'(cfg.ratio_threshold);
		end
	end
	assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Rectified level, saturated to the envelope range
	assign rect_c   = (|p_q[PROD_W-1:ENV_W+4]) ? ENV_MAX : p_q[ENV_W+3:4];
	assign rising_c = rect_c > env_q;
	assign coef_sel = rising_c ? cfg.attack_coef : cfg.decay_coef;
	assign coef_sat = (coef_sel > COEF_ONE) ? COEF_ONE : coef_sel;

	// Follower update
	assign step_c   = p_q[PROD_W-1:16];
	assign rise_sum = (ENV_W + 2)'(env_q) + (ENV_W + 2)'(step_c);
	assign env_up   = (|rise_sum[ENV_W+1:ENV_W]) ? ENV_MAX : rise_sum[ENV_W-1:0];
	assign env_dn   = (step_c > (ENV_W + 1)'(env_q)) ? '0 : env_q - step_c[ENV_W-1:0];
	assign env_new  = rising_q ? env_up : env_dn;

	assign wp_next = (wp_q == LAST_POS) ? '0 : wp_q + 1'b1;

	// Delayed tap, taken after the write pointer has advanced
	assign rd_sum     = (AW + 1)'(wp_q) + DEPTH_X - (AW + 1)'(win_mod);
	assign rd_wrap    = rd_sum - DEPTH_X;
	assign rd_addr    = (rd_sum >= DEPTH_X) ? rd_wrap[AW-1:0] : rd_sum[AW-1:0];
	// Slots not written since the run began read as zero
	assign rd_valid_c = wrapped_q || (rd_addr < wp_q);

	eod_ram #(
		.WIDTH (ENV_W),
		.DEPTH (DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (wp_q),
		.wdata (env_new),
		.re    (cmd.read),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign e_c   = e_valid_q ? ram_rdata : '0;
	assign abs_c = (env_q > e_c) ? env_q - e_c : e_c - env_q;

	assign ratio_ok = PROD_W'({env_q, 8'b0}) > p_q;
	assign cond_c   = ratio_ok && diff_ok_q;
	assign onset_c  = cond_c && !prev_q && fire_ready_q;
	assign hc_base  = onset_c ? '0 : hc_q;
	assign hc_inc   = (hc_base == ENV_MAX) ? hc_base : hc_base + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mag_q <= mag_c;
		end
		if (cmd.mul_gain || cmd.mul_coef || cmd.mul_thr) begin
			p_q <= prod_c;
		end
		if (cmd.sub) begin
			rising_q <= rising_c;
			diff_q   <= rising_c ? rect_c - env_q : env_q - rect_c;
			coef_q   <= coef_sat;
		end
		if (cmd.read) begin
			e_valid_q <= rd_valid_c;
		end
		if (cmd.mul_thr) begin
			diff_ok_q <= abs_c > cfg.diff_threshold;
		end
		if (cmd.finish) begin
			onset_q    <= onset_c;
			envelope_q <= env_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q        <= '0;
			wp_q         <= '0;
			wrapped_q    <= 1'b0;
			prev_q       <= 1'b0;
			hc_q         <= '0;
			fire_ready_q <= 1'b1;
		end else begin
			if (cmd.accept && first) begin
				env_q        <= '0;
				wp_q         <= '0;
				wrapped_q    <= 1'b0;
				prev_q       <= 1'b0;
				hc_q         <= '0;
				fire_ready_q <= 1'b1;
			end
			if (cmd.update) begin
				env_q <= env_new;
				wp_q  <= wp_next;
				if (wp_q == LAST_POS) begin
					wrapped_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				prev_q       <= cond_c;
				hc_q         <= hc_inc;
				fire_ready_q <= (fire_ready_q && !onset_c) ||
				                (hc_inc >= cfg.holdoff_samples);
			end
		end
	end

	assign onset    = onset_q;
	assign envelope = envelope_q;

	a_holdoff_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && onset_c) |=> hc_q == ENV_W'(1))
		else $error("hold-off count not restarted by an onset");

	a_decay_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !rising_q) |=> env_q <= $past(env_q))
		else $error("envelope rose on a falling step");

endmodule

### src/envelope_onset_detector.sv
// Envelope follower with onset detection, one audio sample per beat.
// Input channel (in_valid/in_ready): sample is a signed 16-bit value; first
// restarts a run, clearing the envelope, delay history, pointers and the
// hold-off counter before the sample is used.
// Output channel (out_valid/out_ready): one beat per input beat, carrying the
// onset flag and the new envelope (unsigned Q16.8).
// Configuration: cfg_wen writes cfg_wdata to register cfg_index at the clock
// edge; indexes beyond the last register are ignored. Write only while idle.
// Sequence: a sample is taken in the idle step, then goes through the gain multiply,
// subtract, coefficient multiply, update, read, threshold multiply and final steps; the
// result is loaded into the output register in the final step; a new sample is taken only
// in idle. The steps follow the single 24x17 multiplier, used in turn for gain, follower step
// and ratio compare, and the history RAM, written, then read with a registered read port.
// A compare_window write reduces the window modulo DEPTH, holding in_ready low while busy.
// Reset: registers return to their default values; the history needs no clearing
// pass, since entries not written since the run began are tracked by the write
// pointer and a wrap flag and read as zero.
// Receiver stall: the result waits in the output register and the next sample
// is still taken and worked on; the block holds in its last step until taken.
module envelope_onset_detector #(
	parameter int DEPTH = 65536
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [eod_pkg::SAMPLE_W-1:0] sample,
	input  logic                             first,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             onset,
	output logic [eod_pkg::ENV_W-1:0]        envelope,
	input  logic                             cfg_wen,
	input  logic [eod_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [eod_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import eod_pkg::*;

	eod_cfg_t                 cfg_q;
	eod_cmd_t                 cmd;
	logic                     win_busy;
	logic [$clog2(DEPTH)-1:0] win_mod;
	logic                     win_start;

	// Configuration registers; the window lives in the reduction unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_gain      <= GAIN_RESET;
			cfg_q.attack_coef     <= ATTACK_RESET;
			cfg_q.decay_coef      <= '0;
			cfg_q.ratio_threshold <= '0;
			cfg_q.diff_threshold  <= '0;
			cfg_q.holdoff_samples <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_LEVEL_GAIN:      cfg_q.level_gain      <= cfg_wdata[GAIN_W-1:0];
				CFG_ATTACK_COEF:     cfg_q.attack_coef     <= cfg_wdata[COEF_W-1:0];
				CFG_DECAY_COEF:      cfg_q.decay_coef      <= cfg_wdata[COEF_W-1:0];
				CFG_RATIO_THRESHOLD: cfg_q.ratio_threshold <= cfg_wdata[THR_W-1:0];
				CFG_DIFF_THRESHOLD:  cfg_q.diff_threshold  <= cfg_wdata[ENV_W-1:0];
				CFG_HOLDOFF_SAMPLES: cfg_q.holdoff_samples <= cfg_wdata[ENV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Reduce the window modulo the history depth once per write
	assign win_start = cfg_wen && (cfg_index == CFG_COMPARE_WINDOW);

	eod_winmod #(
		.DEPTH (DEPTH)
	) u_winmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (win_start),
		.window  (cfg_wdata[WIN_W-1:0]),
		.busy    (win_busy),
		.win_mod (win_mod)
	);

	// Sequencer: one step of the datapath per cycle, holding in the last step while the output is full
	eod_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.win_busy  (win_busy),
		.cmd       (cmd)
	);

	// Follower, history store, compares and hold-off
	eod_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.win_mod  (win_mod),
		.sample   (sample),
		.first    (first),
		.onset    (onset),
		.envelope (envelope)
	);

endmodule

### sim/envelope_onset_detector_test.sv
`timescale 1ns / 100ps

module envelope_onset_detector_test;
	import eod_pkg::*;

	localparam int DEPTH = 65536;
	localparam int AW    = $clog2(DEPTH);
	// Index past the last register: writes to it must leave every setting alone
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	// Cycles with no beat on either channel and no register write before giving up
	localparam int IDLE_LIMIT = 3000;
	// Length of the receiver's long hold-off in the back-pressure test
	localparam int LONG_HOLD = 400;
	// Cycles to watch for stray result beats once everything has come back
	localparam int TAIL_CYCLES = 24;

	typedef struct packed {
		logic             onset;
		logic [ENV_W-1:0] envelope;
	} onset_beat_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                  first     = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  onset;
	logic [ENV_W-1:0]      envelope;
	logic                  cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Register shadows, starting from the reset values
	logic [GAIN_W-1:0] gain_q    = GAIN_RESET;
	logic [COEF_W-1:0] attack_q  = ATTACK_RESET;
	logic [COEF_W-1:0] decay_q   = '0;
	logic [WIN_W-1:0]  window_q  = '0;
	logic [THR_W-1:0]  ratio_q   = '0;
	logic [ENV_W-1:0]  diff_q    = '0;
	logic [ENV_W-1:0]  holdoff_q = '0;

	// Follower and detector state. Each history slot carries the run number
	// it was written in, so a new run reads every slot as zero without a sweep.
	logic [ENV_W-1:0] env_level  = '0;
	logic [ENV_W-1:0] env_store [DEPTH];
	int               store_run [DEPTH];
	int               run_id     = 1;
	int               store_wr   = 0;
	logic             was_cond   = 1'b0;
	logic [ENV_W-1:0] hold_count = '0;
	logic             arm_fire   = 1'b1;

	onset_beat_t expected_beats[$];
	int          err_cnt       = 0;
	int          stall_cycles  = 0;
	int          long_hold_req = 0;
	bit          quiet         = 1'b0;

	envelope_onset_detector #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.first    (first),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.onset    (onset),
		.envelope (envelope),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Work out the result of one accepted sample beat and queue it.
	task automatic predict_beat(input logic signed [SAMPLE_W-1:0] smp, input logic frst);
		logic [16:0]       mag;
		logic [39:0]       rect;
		logic [COEF_W-1:0] coef;
		logic [ENV_W-1:0]  span;
		logic [ENV_W-1:0]  step;
		logic [ENV_W-1:0]  back;
		logic [ENV_W-1:0]  spread;
		logic [40:0]       prod;
		logic              rising;
		logic              cond;
		onset_beat_t       beat;
		int                rd;
		// A new run: drop the envelope, history, pointer and hold-off state
		if (frst) begin
			run_id++;
			env_level  = '0;
			store_wr   = 0;
			was_cond   = 1'b0;
			hold_count = '0;
			arm_fire   = 1'b1;
		end
		// Rectify, scale by the Q4.12 gain and clip to the envelope range
		mag  = smp[SAMPLE_W-1] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
		rect = (40'(mag) * 40'(gain_q)) >> 4;
		if (rect > 40'(ENV_MAX))
			rect = 40'(ENV_MAX);
		// One-pole follower; coefficients above one act as one
		rising = rect[ENV_W-1:0] > env_level;
		coef   = rising ? attack_q : decay_q;
		if (coef > COEF_ONE)
			coef = COEF_ONE;
		span = rising ? rect[ENV_W-1:0] - env_level : env_level - rect[ENV_W-1:0];
		prod = 41'(span) * 41'(coef);
		step = prod[ENV_W+15:16];
		if (rising)
			env_level = (25'(env_level) + 25'(step) > 25'(ENV_MAX)) ? ENV_MAX : env_level + step;
		else
			env_level = (step > env_level) ? '0 : env_level - step;
		// Store, advance, then read the tap relative to the advanced pointer
		env_store[AW'(store_wr)] = env_level;
		store_run[AW'(store_wr)] = run_id;
		store_wr = (store_wr + 1) % DEPTH;
		rd   = (store_wr + DEPTH - int'(window_q) % DEPTH) % DEPTH;
		back = (store_run[AW'(rd)] == run_id) ? env_store[AW'(rd)] : '0;
		spread = (env_level > back) ? env_level - back : back - env_level;
		// Ratio test as a product compare, so a zero tap passes on any non-zero level
		cond = (48'(env_level) * 48'd256 > 48'(ratio_q) * 48'(back)) && (spread > diff_q);
		beat.onset = cond && !was_cond && arm_fire;
		if (beat.onset) begin
			hold_count = '0;
			arm_fire   = 1'b0;
		end
		was_cond = cond;
		if (hold_count < ENV_MAX)
			hold_count++;
		// A zero hold-off re-arms on the same beat
		if (hold_count >= holdoff_q)
			arm_fire = 1'b1;
		beat.envelope = env_level;
		expected_beats.push_back(beat);
	endtask

	// Offer one sample beat after a random gap and hold it until taken. Valid is
	// left high on return so a back-to-back beat follows without a dip.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic frst);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= smp;
		first    <= frst;
		do @(posedge clk); while (!(in_valid && in_ready));
		predict_beat(smp, frst);
	endtask

	// Drop valid and wait for every outstanding result beat.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_LEVEL_GAIN:      gain_q    = val[GAIN_W-1:0];
			CFG_ATTACK_COEF:     attack_q  = val[COEF_W-1:0];
			CFG_DECAY_COEF:      decay_q   = val[COEF_W-1:0];
			CFG_COMPARE_WINDOW:  window_q  = val[WIN_W-1:0];
			CFG_RATIO_THRESHOLD: ratio_q   = val[THR_W-1:0];
			CFG_DIFF_THRESHOLD:  diff_q    = val[ENV_W-1:0];
			CFG_HOLDOFF_SAMPLES: holdoff_q = val[ENV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] atk,
			input logic [CFG_DATA_W-1:0] dcy, input logic [CFG_DATA_W-1:0] win,
			input logic [CFG_DATA_W-1:0] ratio, input logic [CFG_DATA_W-1:0] diff,
			input logic [CFG_DATA_W-1:0] hold);
		write_reg(CFG_LEVEL_GAIN, gain);
		write_reg(CFG_ATTACK_COEF, atk);
		write_reg(CFG_DECAY_COEF, dcy);
		write_reg(CFG_COMPARE_WINDOW, win);
		write_reg(CFG_RATIO_THRESHOLD, ratio);
		write_reg(CFG_DIFF_THRESHOLD, diff);
		write_reg(CFG_HOLDOFF_SAMPLES, hold);
	endtask

	// Reset settings: sample extremes, a run started without the first flag
	// (history reads zero from reset) and then with it. The oldest slot is
	// tapped since the window is zero.
	task automatic test_extremes_at_reset();
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'shFFFF, 1'b0);
		send_sample(16'sh0001, 1'b1);
		send_sample(16'sh3039, 1'b0);
	endtask

	// Full gain saturates the rectifier; an attack coefficient above one is
	// clipped to one; full decay drops straight to the rectified level.
	task automatic test_saturation_and_coefs();
		wait_drained();
		set_config(24'd65535, 24'd131071, 24'd65536, 24'd2, 24'd256, 24'd0, 24'd3);
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
	endtask

	// Window equal to the depth wraps to the oldest slot; maximum thresholds
	// and zero gain; a write to the unused index must change nothing.
	task automatic test_window_wrap_and_max_thresholds();
		wait_drained();
		set_config(24'd0, 24'd65536, 24'd0, 24'd65536, 24'd65535, ENV_MAX, ENV_MAX);
		write_reg(CFG_UNUSED, 24'hFFFFFF);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh0064, 1'b0);
	endtask

	// Long hold-off blocks a second onset; lowering it mid-run releases the
	// detector as soon as the count has reached the new value.
	task automatic test_holdoff_lowered();
		wait_drained();
		set_config(24'd4096, 24'd65536, 24'd65536, 24'd2, 24'd0, 24'd0, 24'd100);
		send_sample(16'sd1000, 1'b1);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd1000, 1'b0);
		send_sample(16'sd0, 1'b0);
		wait_drained();
		write_reg(CFG_HOLDOFF_SAMPLES, 24'd2);
		send_sample(16'sd1000, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd1000, 1'b0);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering
	// beats with no gaps, so the block fills and stalls its input.
	task automatic test_backpressure();
		wait_drained();
		set_config(24'd4096, 24'd30000, 24'd8000, 24'd3, 24'd300, 24'd5000, 24'd2);
		long_hold_req++;
		quiet = 1'b1;
		for (int i = 0; i < 12; i++)
			send_sample(16'($urandom), i == 0);
		quiet = 1'b0;
	endtask

	// Sender pauses mid-run until every result has come back, then carries on.
	task automatic test_sender_pause();
		for (int i = 0; i < 10; i++)
			send_sample(16'($urandom_range(0, 20000)), 1'b0);
		wait_drained();
		for (int i = 0; i < 10; i++)
			send_sample(16'($urandom_range(0, 20000)), 1'b0);
	endtask

	// Random settings per run, then bursty audio: runs of near silence and loud
	// bursts so the detector sees rising edges, with some noise and extremes.
	task automatic test_random_runs();
		logic [CFG_DATA_W-1:0] gain, atk, dcy, win, ratio, diff, hold;
		logic signed [SAMPLE_W-1:0] smp;
		int seg_kind;
		int seg_left;
		for (int run = 0; run < 8; run++) begin
			wait_drained();
			case ($urandom_range(0, 5))
				0:       gain = 24'd0;
				1:       gain = 24'd65535;
				2:       gain = GAIN_RESET;
				default: gain = 24'($urandom_range(1024, 16384));
			endcase
			case ($urandom_range(0, 4))
				0:       atk = 24'd0;
				1:       atk = 24'd65536;
				default: atk = 24'($urandom_range(1000, 65536));
			endcase
			case ($urandom_range(0, 4))
				0:       dcy = 24'd0;
				1:       dcy = 24'd65536;
				default: dcy = 24'($urandom_range(500, 65536));
			endcase
			case ($urandom_range(0, 5))
				0:       win = 24'd0;
				1:       win = 24'd1;
				2:       win = 24'd65536;
				default: win = 24'($urandom_range(2, 12));
			endcase
			case ($urandom_range(0, 5))
				0:       ratio = 24'd0;
				1:       ratio = 24'd65535;
				2:       ratio = 24'd256;
				default: ratio = 24'($urandom_range(0, 768));
			endcase
			case ($urandom_range(0, 5))
				0:       diff = 24'd0;
				1:       diff = ENV_MAX;
				default: diff = 24'($urandom_range(0, 200000));
			endcase
			case ($urandom_range(0, 7))
				0:       hold = 24'd0;
				1:       hold = ENV_MAX;
				default: hold = 24'($urandom_range(1, 12));
			endcase
			set_config(gain, atk, dcy, win, ratio, diff, hold);
			// One run with no idling on either side
			quiet    = (run == 3);
			seg_left = 0;
			seg_kind = 0;
			for (int i = 0; i < 45; i++) begin
				if (seg_left == 0) begin
					seg_kind = $urandom_range(0, 9);
					seg_left = $urandom_range(2, 8);
				end
				seg_left--;
				case (seg_kind)
					0, 1, 2, 3: begin
						smp = 16'($urandom_range(0, 128));
						if ($urandom_range(0, 1))
							smp = -smp;
					end
					4, 5, 6, 7: begin
						smp = 16'($urandom_range(4000, 32767));
						if ($urandom_range(0, 1))
							smp = -smp;
					end
					8: smp = 16'($urandom);
					default: begin
						case ($urandom_range(0, 3))
							0:       smp = 16'sh7FFF;
							1:       smp = 16'sh8000;
							2:       smp = 16'sh0000;
							default: smp = 16'shFFFF;
						endcase
					end
				endcase
				send_sample(smp, (i == 0) || ($urandom_range(0, 39) == 0));
			end
			quiet = 1'b0;
		end
	endtask

	// Result sink: stall a random number of cycles before each beat, or for the
	// long stretch when one is requested.
	initial begin : result_sink
		int wait_cycles;
		int holds_done;
		holds_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_req != holds_done) begin
				wait_cycles = LONG_HOLD;
				holds_done  = long_hold_req;
			end else begin
				wait_cycles = quiet ? 0 : $urandom_range(0, 6);
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Compare every result beat with the oldest expectation.
	always @(posedge clk) begin : check_beat
		onset_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected result beat, onset %0d envelope %0d",
					$time, onset, envelope);
				err_cnt++;
			end else begin
				want = expected_beats.pop_front();
				if (onset !== want.onset) begin
					$display("%0t: onset mismatch, expected %0d, actual %0d",
						$time, want.onset, onset);
					err_cnt++;
				end
				if (envelope !== want.envelope) begin
					$display("%0t: envelope mismatch, expected %0d, actual %0d",
						$time, want.envelope, envelope);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: count cycles with no beat and no register write.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= IDLE_LIMIT) begin
			$display("envelope_onset_detector_test failed");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes_at_reset();
		test_saturation_and_coefs();
		test_window_wrap_and_max_thresholds();
		test_holdoff_lowered();
		test_backpressure();
		test_sender_pause();
		test_random_runs();
		wait_drained();
		// Watch for stray beats after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && expected_beats.size() == 0)
			$display("envelope_onset_detector_test passed");
		else
			$display("envelope_onset_detector_test failed");
		$finish;
	end

endmodule
